>>> sv/rlx_pkg.sv
// shared types and constants for the record parser with lcg/xor decryption
// used by rlx_core, rlx_outq and record_parser_lcg_xor_decrypt; no dependencies
package rlx_pkg;

  localparam logic [31:0] LCG_MUL   = 32'h0019_660D;
  localparam logic [31:0] LCG_ADD   = 32'h3C6E_F35F;
  localparam logic [31:0] REC_MAGIC = 32'h4441_4742;

  localparam logic [4:0] HDR_BYTES = 5'd24;
  localparam logic [4:0] HDR_LAST  = 5'd23;

  localparam logic [15:0] MAX_NAME_LEN_RST  = 16'h0100;
  localparam logic [31:0] MAX_DATA_SIZE_RST = 32'h0100_0000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_NAME_LEN  = 1'b0,
    CFG_MAX_DATA_SIZE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_HEADER = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_NAME_LEN  = 3'd2,
    ERR_DATA_SIZE = 3'd3,
    ERR_UNPACKED  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    err_e        error_code;
    logic        last;
    logic        compressed;
    logic [15:0] name_len;
    logic [31:0] stored_size;
    logic [31:0] unpacked_size;
    logic [15:0] data_kind;
  } result_t;

  localparam result_t RESULT_NONE = '{
    kind:          KIND_NAME,
    value:         8'h00,
    error_code:    ERR_NONE,
    last:          1'b0,
    compressed:    1'b0,
    name_len:      16'h0000,
    stored_size:   32'h0000_0000,
    unpacked_size: 32'h0000_0000,
    data_kind:     16'h0000
  };

endpackage

>>> sv/rlx_core.sv
// record state machine: header capture, checks and keystream decryption
// one byte per fire, up to two results; depends on rlx_pkg
module rlx_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic [15:0]      max_name_len_i,
  input  logic [31:0]      max_data_size_i,
  output logic [1:0]       res_cnt_o,
  output rlx_pkg::result_t res0_o,
  output rlx_pkg::result_t res1_o
);
  import rlx_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] magic_q, magic_d;
  logic [15:0] name_len_q, name_len_d;
  logic [15:0] type_q, type_d;
  logic [15:0] comp_q, comp_d;
  logic [31:0] dsize_q, dsize_d;
  logic [31:0] unpacked_q, unpacked_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  lane_q, lane_d;
  logic [31:0] remaining_q, remaining_d;

  logic [31:0] key_step;
  logic [31:0] key_n;
  logic [7:0]  crypt_val;
  logic [31:0] rem_dec;

  // key advances at the start of each group of four bytes
  assign key_step  = key_q * LCG_MUL + LCG_ADD;
  assign key_n     = (lane_q == 2'd0) ? key_step : key_q;
  assign crypt_val = byte_i ^ key_n[{lane_q, 3'b000} +: 8];
  assign rem_dec   = remaining_q - 32'd1;

  always_comb begin
    logic [4:0] p;
    logic       do_enter;
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    magic_d     = magic_q;
    name_len_d  = name_len_q;
    type_d      = type_q;
    comp_d      = comp_q;
    dsize_d     = dsize_q;
    unpacked_d  = unpacked_q;
    key_d       = key_q;
    lane_d      = lane_q;
    remaining_d = remaining_q;
    res0_o      = RESULT_NONE;
    res1_o      = RESULT_NONE;
    res_cnt_o   = 2'd0;
    do_enter    = 1'b0;
    p           = (hdr_cnt_q >= HDR_BYTES) ? 5'd0 : hdr_cnt_q;

    case (phase_q)
      PH_NAME: begin
        key_d          = key_n;
        lane_d         = lane_q + 2'd1;
        remaining_d    = rem_dec;
        res0_o.kind    = KIND_NAME;
        res0_o.value   = crypt_val;
        res0_o.last    = (rem_dec == 32'd0);
        res_cnt_o      = 2'd1;
        do_enter       = (rem_dec == 32'd0);
      end
      PH_DATA: begin
        key_d          = key_n;
        lane_d         = lane_q + 2'd1;
        remaining_d    = rem_dec;
        res0_o.kind    = KIND_DATA;
        res0_o.value   = crypt_val;
        res0_o.last    = (rem_dec == 32'd0);
        res_cnt_o      = 2'd1;
        if (rem_dec == 32'd0) begin
          phase_d = PH_HEADER;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        // little-endian header layout by byte offset
        if (p < 5'd4) begin
          magic_d[{p[1:0], 3'b000} +: 8] = byte_i;
        end else if (p == 5'd10 || p == 5'd11) begin
          name_len_d[{p[0], 3'b000} +: 8] = byte_i;
        end else if (p == 5'd12 || p == 5'd13) begin
          type_d[{p[0], 3'b000} +: 8] = byte_i;
        end else if (p == 5'd14 || p == 5'd15) begin
          comp_d[{p[0], 3'b000} +: 8] = byte_i;
        end else if (p >= 5'd16 && p < 5'd20) begin
          dsize_d[{p[1:0], 3'b000} +: 8] = byte_i;
        end else if (p >= 5'd20) begin
          unpacked_d[{p[1:0], 3'b000} +: 8] = byte_i;
        end

        if (p != HDR_LAST) begin
          hdr_cnt_d = p + 5'd1;
        end else begin
          hdr_cnt_d = 5'd0;
          res_cnt_o = 2'd1;
          if (magic_d != REC_MAGIC) begin
            res0_o.kind       = KIND_ERROR;
            res0_o.error_code = ERR_MAGIC;
          end else if (name_len_d > max_name_len_i) begin
            res0_o.kind       = KIND_ERROR;
            res0_o.error_code = ERR_NAME_LEN;
          end else begin
            res0_o.kind          = KIND_HEADER;
            res0_o.compressed    = (comp_d != 16'h0000);
            res0_o.name_len      = name_len_d;
            res0_o.stored_size   = dsize_d;
            res0_o.unpacked_size = unpacked_d;
            res0_o.data_kind     = type_d;
            if (name_len_d != 16'h0000) begin
              phase_d     = PH_NAME;
              remaining_d = {16'h0000, name_len_d};
              key_d       = dsize_d;
              lane_d      = 2'd0;
            end else begin
              do_enter = 1'b1;
            end
          end
        end
      end
    endcase

    // size checks ahead of the data section
    if (do_enter) begin
      if (dsize_d > max_data_size_i) begin
        res1_o.kind       = KIND_ERROR;
        res1_o.error_code = ERR_DATA_SIZE;
        res_cnt_o         = 2'd2;
        phase_d           = PH_HEADER;
      end else if (unpacked_d > max_data_size_i) begin
        res1_o.kind       = KIND_ERROR;
        res1_o.error_code = ERR_UNPACKED;
        res_cnt_o         = 2'd2;
        phase_d           = PH_HEADER;
      end else if (dsize_d == 32'd0) begin
        phase_d = PH_HEADER;
      end else begin
        phase_d     = PH_DATA;
        remaining_d = dsize_d;
        key_d       = {16'h0000, name_len_d};
        lane_d      = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= 5'd0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      magic_q     <= magic_d;
      name_len_q  <= name_len_d;
      type_q      <= type_d;
      comp_q      <= comp_d;
      dsize_q     <= dsize_d;
      unpacked_q  <= unpacked_d;
      key_q       <= key_d;
      lane_q      <= lane_d;
      remaining_q <= remaining_d;
    end
  end

  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q < HDR_BYTES)
    else $error("header byte counter out of range");

  a_res_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o != 2'd3)
    else $error("more than two results for one byte");

  a_second_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o == 2'd2 |-> res1_o.kind == KIND_ERROR && res1_o.error_code != ERR_NONE)
    else $error("second result of a byte is not a size error");

endmodule

>>> sv/rlx_outq.sv
// two-entry result queue in fixed registers, takes up to two results a cycle
// head register drives the output channel; depends on rlx_pkg
module rlx_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  rlx_pkg::result_t res0_i,
  input  rlx_pkg::result_t res1_i,
  input  logic             pop_i,
  output rlx_pkg::result_t head_o,
  output logic [1:0]       cnt_o
);
  import rlx_pkg::*;

  result_t    slot0_q, slot0_d;
  result_t    slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] cnt_p;

  always_comb begin
    cnt_p = cnt_q - {1'b0, pop_i};
    if (cnt_p == 2'd0) begin
      slot0_d = res0_i;
      slot1_d = res1_i;
    end else if (cnt_p == 2'd1) begin
      slot0_d = pop_i ? slot1_q : slot0_q;
      slot1_d = res0_i;
    end else begin
      slot0_d = slot0_q;
      slot1_d = slot1_q;
    end
    cnt_d = cnt_p + push_cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign head_o = slot0_q;
  assign cnt_o  = cnt_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q - {1'b0, pop_i}) + push_cnt_i <= 2'd2 && push_cnt_i != 2'd3)
    else $error("result queue overflow");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && push_cnt_i == 2'd0 |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("result queue count did not drop on pop");

endmodule

>>> sv/record_parser_lcg_xor_decrypt.sv
// Record parser with lcg/xor stream decryption. Raw record bytes enter one per cycle
// through an input register; a single combinational pass over the record state then
// produces zero, one or two result transactions into a two-entry output queue. The
// block sustains one byte per cycle; the last header byte or the last name byte can
// yield two transactions (report or name byte plus a size error), and the output
// side moves one transaction per cycle while out_stall_i is low, so input stalls
// only while the queue, after this cycle's output transaction, has no room for all
// results of the held byte. Results reach the outputs from the queue head register.
// top level; depends on rlx_pkg, rlx_core and rlx_outq
module record_parser_lcg_xor_decrypt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte stream in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  // results out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     value_o,
  output logic [2:0]                     error_code_o,
  output logic                           last_o,
  output logic                           compressed_o,
  output logic [15:0]                    name_length_out_o,
  output logic [31:0]                    data_size_out_o,
  output logic [31:0]                    unpacked_size_o,
  output logic [15:0]                    data_kind_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rlx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rlx_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rlx_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic [15:0] max_name_len_q;
  logic [31:0] max_data_size_q;

  logic        fire;
  logic        pop;
  logic        in_accept;
  logic [1:0]  res_cnt;
  logic [1:0]  q_cnt;
  logic [2:0]  q_need;
  result_t     res0, res1, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_len_q  <= MAX_NAME_LEN_RST;
      max_data_size_q <= MAX_DATA_SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MAX_NAME_LEN:  max_name_len_q  <= cfg_data_i[15:0];
        CFG_MAX_DATA_SIZE: max_data_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // process the held byte when the queue has room for its results
  assign pop    = (q_cnt != 2'd0) && !out_stall_i;
  assign q_need = {1'b0, q_cnt} - {2'b00, pop} + {1'b0, res_cnt};
  assign fire   = in_valid_q && (q_need <= 3'd2);

  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  rlx_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .byte_i          (in_byte_q),
    .max_name_len_i  (max_name_len_q),
    .max_data_size_i (max_data_size_q),
    .res_cnt_o       (res_cnt),
    .res0_o          (res0),
    .res1_o          (res1)
  );

  rlx_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (fire ? res_cnt : 2'd0),
    .res0_i     (res0),
    .res1_i     (res1),
    .pop_i      (pop),
    .head_o     (head),
    .cnt_o      (q_cnt)
  );

  assign out_valid_o       = (q_cnt != 2'd0);
  assign kind_o            = head.kind;
  assign value_o           = head.value;
  assign error_code_o      = head.error_code;
  assign last_o            = head.last;
  assign compressed_o      = head.compressed;
  assign name_length_out_o = head.name_len;
  assign data_size_out_o   = head.stored_size;
  assign unpacked_size_o   = head.unpacked_size;
  assign data_kind_o       = head.data_kind;

  a_fire_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> in_valid_q)
    else $error("processing without a held byte");

  a_held_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_byte_q))
    else $error("held byte lost while waiting for queue room");

  a_empty_queue_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && q_cnt == 2'd0 |-> fire)
    else $error("stalled with an empty result queue");

endmodule
